// ===== hw/rtl/ubt_pkg.sv =====
// ubt_pkg: shared types and constants for the uart byte transmitter
// holds the phase encoding, command codes and reset defaults
// no dependencies
`timescale 1ns / 1ps

package ubt_pkg;

    localparam int unsigned DataBitsDefault = 8;
    localparam logic [7:0] WaitTicksReset = 8'd12;
    localparam logic [7:0] TickCountMax = 8'hFF;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_START = 2'd2
    } command_t;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_START  = 5'b00010,
        PH_DWELL  = 5'b00100,
        PH_BIT    = 5'b01000,
        PH_FINISH = 5'b10000
    } phase_t;

endpackage

// ===== hw/rtl/uart_byte_transmitter_top.sv =====
// uart_byte_transmitter_top: 8n1 serial transmitter stepped one command at a time
// depends on ubt_pkg for phase encoding, command codes and reset values
//
// usage:
//   command channel (cmd_valid / cmd_stall, command, data_byte): each transfer is
//   a tick (0), a pending byte write (1) or a start request (2); code 3 changes
//   nothing but still yields a result
//   result channel (res_valid / res_stall, tx_line, busy_res): exactly one result
//   per command, giving the line level and busy flag after that command
//   wait_ticks_we / wait_ticks_wdata write the dwell count, only while idle; the block does not enforce this
// results: each result is registered in the result register, or first in the skid entry while that register is held
// throughput: one command per cycle while cmd_stall is low, set by the single
//   state update register stage; the result register plus one skid entry let a
//   command be taken while a result waits
// stall: with the result register and the skid entry both full, cmd_stall rises
//   until the receiver takes a result; no result is lost or repeated
// reset: line high, idle, counters and bytes zero, wait_ticks back to 12,
//   both result entries empty
`timescale 1ns / 1ps

module uart_byte_transmitter_top #(
    parameter int unsigned DATA_BITS = ubt_pkg::DataBitsDefault
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_stall,
    input  logic [1:0] command,
    input  logic [7:0] data_byte,
    output logic       res_valid,
    input  logic       res_stall,
    output logic       tx_line,
    output logic       busy_res,
    input  logic       wait_ticks_we,
    input  logic [7:0] wait_ticks_wdata
);

    localparam logic [3:0] DataBitsC  = 4'(DATA_BITS);
    localparam logic [3:0] FrameBitsC = 4'(DATA_BITS + 1);

    logic [7:0]      wait_ticks_reg;
    ubt_pkg::phase_t phase_reg, phase_next;
    logic [3:0]      bit_count_reg, bit_count_next;
    logic [7:0]      tick_count_reg, tick_count_next;
    logic            start_pending_reg, start_pending_next;
    logic [7:0]      pending_byte_reg, pending_byte_next;
    logic [7:0]      shift_byte_reg, shift_byte_next;
    logic            line_level_reg, line_level_next;

    logic            res_valid_reg, res_valid_next;
    logic            res_line_reg, res_line_next;
    logic            res_busy_reg, res_busy_next;
    logic            skid_valid_reg, skid_valid_next;
    logic            skid_line_reg, skid_line_next;
    logic            skid_busy_reg, skid_busy_next;

    logic            cmd_fire;
    logic            out_free;
    logic [7:0]      tick_inc;
    logic            new_line;
    logic            new_busy;

    assign cmd_stall = skid_valid_reg;
    assign cmd_fire  = cmd_valid & ~skid_valid_reg;
    assign out_free  = ~res_valid_reg | ~res_stall;
    assign tick_inc  = (tick_count_reg != ubt_pkg::TickCountMax) ?
                       tick_count_reg + 8'd1 : tick_count_reg;

    // state update for one command
    always_comb
    begin
        phase_next         = phase_reg;
        bit_count_next     = bit_count_reg;
        tick_count_next    = tick_count_reg;
        start_pending_next = start_pending_reg;
        pending_byte_next  = pending_byte_reg;
        shift_byte_next    = shift_byte_reg;
        line_level_next    = line_level_reg;
        if (cmd_fire)
        begin
            case (command)
                ubt_pkg::CMD_TICK:
                begin
                    case (phase_reg)
                        ubt_pkg::PH_IDLE:
                        begin
                            line_level_next = 1'b1;
                            if (start_pending_reg)
                            begin
                                shift_byte_next = pending_byte_reg;
                                phase_next      = ubt_pkg::PH_START;
                            end
                        end
                        ubt_pkg::PH_START:
                        begin
                            line_level_next = 1'b0;
                            bit_count_next  = 4'd0;
                            tick_count_next = 8'd0;
                            phase_next      = ubt_pkg::PH_DWELL;
                        end
                        ubt_pkg::PH_DWELL:
                        begin
                            tick_count_next = tick_inc;
                            if (tick_inc >= wait_ticks_reg)
                            begin
                                if (bit_count_reg < FrameBitsC)
                                    phase_next = ubt_pkg::PH_BIT;
                                else
                                    phase_next = ubt_pkg::PH_FINISH;
                            end
                        end
                        ubt_pkg::PH_BIT:
                        begin
                            tick_count_next = 8'd0;
                            if (bit_count_reg < DataBitsC)
                            begin
                                line_level_next = shift_byte_reg[0];
                                shift_byte_next = {1'b0, shift_byte_reg[7:1]};
                            end
                            else
                            begin
                                line_level_next = 1'b1;
                            end
                            bit_count_next = bit_count_reg + 4'd1;
                            phase_next     = ubt_pkg::PH_DWELL;
                        end
                        ubt_pkg::PH_FINISH:
                        begin
                            start_pending_next = 1'b0;
                            phase_next         = ubt_pkg::PH_IDLE;
                        end
                        default:
                        begin
                            line_level_next = 1'b1;
                            phase_next      = ubt_pkg::PH_IDLE;
                        end
                    endcase
                end
                ubt_pkg::CMD_WRITE:
                begin
                    pending_byte_next = data_byte;
                end
                ubt_pkg::CMD_START:
                begin
                    start_pending_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign new_line = line_level_next;
    assign new_busy = (phase_next != ubt_pkg::PH_IDLE);

    // result register with one skid entry
    always_comb
    begin
        res_valid_next  = res_valid_reg;
        res_line_next   = res_line_reg;
        res_busy_next   = res_busy_reg;
        skid_valid_next = skid_valid_reg;
        skid_line_next  = skid_line_reg;
        skid_busy_next  = skid_busy_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                res_line_next = skid_line_reg;
                res_busy_next = skid_busy_reg;
            end
            else
            begin
                res_line_next = new_line;
                res_busy_next = new_busy;
            end
            res_valid_next  = skid_valid_reg | cmd_fire;
            skid_valid_next = 1'b0;
        end
        else if (cmd_fire)
        begin
            skid_valid_next = 1'b1;
            skid_line_next  = new_line;
            skid_busy_next  = new_busy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_ticks_reg    <= ubt_pkg::WaitTicksReset;
            phase_reg         <= ubt_pkg::PH_IDLE;
            bit_count_reg     <= 4'd0;
            tick_count_reg    <= 8'd0;
            start_pending_reg <= 1'b0;
            pending_byte_reg  <= 8'd0;
            shift_byte_reg    <= 8'd0;
            line_level_reg    <= 1'b1;
            res_valid_reg     <= 1'b0;
            skid_valid_reg    <= 1'b0;
        end
        else
        begin
            if (wait_ticks_we)
                wait_ticks_reg <= wait_ticks_wdata;
            phase_reg         <= phase_next;
            bit_count_reg     <= bit_count_next;
            tick_count_reg    <= tick_count_next;
            start_pending_reg <= start_pending_next;
            pending_byte_reg  <= pending_byte_next;
            shift_byte_reg    <= shift_byte_next;
            line_level_reg    <= line_level_next;
            res_valid_reg     <= res_valid_next;
            skid_valid_reg    <= skid_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        res_line_reg  <= res_line_next;
        res_busy_reg  <= res_busy_next;
        skid_line_reg <= skid_line_next;
        skid_busy_reg <= skid_busy_next;
    end

    assign res_valid = res_valid_reg;
    assign tx_line   = res_line_reg;
    assign busy_res  = res_busy_reg;

endmodule

// ===== tb/sv/tb.sv =====
// tb: self-checking testbench for uart_byte_transmitter_top
// predicts line level and busy flag per command and checks every result transfer
// depends on ubt_pkg and the uart_byte_transmitter_top rtl
`timescale 1ns / 1ps

module tb;

    localparam int DataBits = ubt_pkg::DataBitsDefault;
    localparam int CycleLimit = 500000;
    localparam int HoldCycles = 60;
    localparam int MaxPrinted = 40;
    localparam logic [1:0] CmdUnused = 2'd3;

    typedef struct packed {
        logic line;
        logic busy;
    } line_busy_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cmd_valid = 1'b0;
    logic       cmd_stall;
    logic [1:0] command = '0;
    logic [7:0] data_byte = '0;
    logic       res_valid;
    logic       res_stall = 1'b0;
    logic       tx_line;
    logic       busy_res;
    logic       wait_ticks_we = 1'b0;
    logic [7:0] wait_ticks_wdata = '0;

    // predicted transmitter state
    ubt_pkg::phase_t tx_phase = ubt_pkg::PH_IDLE;
    logic [3:0] bit_cnt = '0;
    logic [7:0] tick_cnt = '0;
    logic       start_req = 1'b0;
    logic [7:0] pend_byte = '0;
    logic [7:0] shift_reg = '0;
    logic       line_lvl = 1'b1;
    logic [7:0] dwell_ticks = ubt_pkg::WaitTicksReset;

    line_busy_t line_busy_q[$];
    int err_count = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    bit hold_req = 1'b0;

    uart_byte_transmitter_top #(
        .DATA_BITS(DataBits)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .command(command),
        .data_byte(data_byte),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .tx_line(tx_line),
        .busy_res(busy_res),
        .wait_ticks_we(wait_ticks_we),
        .wait_ticks_wdata(wait_ticks_wdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    task automatic report_error(input string msg);
        if (err_count < MaxPrinted)
            $display("tb: %0t ns: %s", $time, msg);
        err_count++;
    endtask

    function automatic void tick_transmitter();
        case (tx_phase)
            ubt_pkg::PH_IDLE:
            begin
                line_lvl = 1'b1;
                if (start_req)
                begin
                    shift_reg = pend_byte;
                    tx_phase = ubt_pkg::PH_START;
                end
            end
            ubt_pkg::PH_START:
            begin
                line_lvl = 1'b0;
                bit_cnt = '0;
                tick_cnt = '0;
                tx_phase = ubt_pkg::PH_DWELL;
            end
            ubt_pkg::PH_DWELL:
            begin
                if (tick_cnt < ubt_pkg::TickCountMax)
                    tick_cnt = tick_cnt + 8'd1;
                if (tick_cnt >= dwell_ticks)
                begin
                    if (int'(bit_cnt) < DataBits + 1)
                        tx_phase = ubt_pkg::PH_BIT;
                    else
                        tx_phase = ubt_pkg::PH_FINISH;
                end
            end
            ubt_pkg::PH_BIT:
            begin
                tick_cnt = '0;
                if (int'(bit_cnt) < DataBits)
                begin
                    line_lvl = shift_reg[0];
                    shift_reg = shift_reg >> 1;
                end
                else
                begin
                    line_lvl = 1'b1;
                end
                bit_cnt = bit_cnt + 4'd1;
                tx_phase = ubt_pkg::PH_DWELL;
            end
            ubt_pkg::PH_FINISH:
            begin
                start_req = 1'b0;
                tx_phase = ubt_pkg::PH_IDLE;
            end
            default:
            begin
                line_lvl = 1'b1;
                tx_phase = ubt_pkg::PH_IDLE;
            end
        endcase
    endfunction

    function automatic line_busy_t step_transmitter(input logic [1:0] cmd,
                                                    input logic [7:0] data);
        line_busy_t r;
        case (cmd)
            ubt_pkg::CMD_TICK:  tick_transmitter();
            ubt_pkg::CMD_WRITE: pend_byte = data;
            ubt_pkg::CMD_START: start_req = 1'b1;
            default:            ;
        endcase
        r.line = line_lvl;
        r.busy = (tx_phase != ubt_pkg::PH_IDLE);
        return r;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        line_busy_t exp_r;
        if (rst_n && res_valid && !res_stall)
        begin
            if (line_busy_q.size() == 0)
            begin
                report_error("result transfer with nothing expected");
            end
            else
            begin
                exp_r = line_busy_q.pop_front();
                if (tx_line !== exp_r.line)
                    report_error($sformatf("tx_line got %b expected %b",
                                           tx_line, exp_r.line));
                if (busy_res !== exp_r.busy)
                    report_error($sformatf("busy_res got %b expected %b",
                                           busy_res, exp_r.busy));
            end
        end
    end

    // receiver stall, with an optional long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            res_stall <= 1'b1;
            hold_left--;
        end
        else if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = HoldCycles - 1;
            res_stall <= 1'b1;
        end
        else
        begin
            res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    task automatic send_cmd(input logic [1:0] cmd, input logic [7:0] data);
        cmd_valid <= 1'b1;
        command <= cmd;
        data_byte <= data;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        line_busy_q.push_back(step_transmitter(cmd, data));
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic run_ticks(input int n);
        repeat (n)
            send_cmd(ubt_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic finish_frame();
        while (tx_phase != ubt_pkg::PH_IDLE || start_req)
            send_cmd(ubt_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic quiesce();
        cmd_valid <= 1'b0;
        while (line_busy_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_wait(input logic [7:0] v);
        quiesce();
        wait_ticks_we <= 1'b1;
        wait_ticks_wdata <= v;
        @(posedge clk);
        dwell_ticks = v;
        wait_ticks_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_wait(input logic [7:0] v);
        finish_frame();
        write_wait(v);
    endtask

    task automatic random_traffic(input int n);
        int r;
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < 6)
                send_cmd(ubt_pkg::CMD_WRITE, 8'($urandom_range(0, 255)));
            else if (r < 10)
                send_cmd(ubt_pkg::CMD_START, 8'($urandom_range(0, 255)));
            else if (r < 12)
                send_cmd(CmdUnused, 8'($urandom_range(0, 255)));
            else
                send_cmd(ubt_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
        end
    endtask

    // default wait, reset pending byte, unused command
    task automatic test_reset_defaults();
        run_ticks(2);
        send_cmd(CmdUnused, 8'hFF);
        send_cmd(ubt_pkg::CMD_START, 8'h00);
        finish_frame();
    endtask

    // all-zero and all-one bytes, start and write during a frame
    task automatic test_directed_frames();
        set_wait(8'd1);
        send_cmd(ubt_pkg::CMD_WRITE, 8'h00);
        send_cmd(ubt_pkg::CMD_START, 8'hFF);
        finish_frame();
        send_cmd(ubt_pkg::CMD_WRITE, 8'hFF);
        send_cmd(ubt_pkg::CMD_START, 8'h00);
        finish_frame();
        send_cmd(ubt_pkg::CMD_WRITE, 8'hA5);
        send_cmd(ubt_pkg::CMD_START, 8'h00);
        run_ticks(5);
        send_cmd(ubt_pkg::CMD_START, 8'h00);
        send_cmd(ubt_pkg::CMD_WRITE, 8'h3C);
        send_cmd(CmdUnused, 8'h00);
        finish_frame();
        run_ticks(3);
    endtask

    // longest dwell through the start bit, dwell shortened within the frame, zero dwell
    task automatic test_wait_extremes();
        set_wait(8'd255);
        send_cmd(ubt_pkg::CMD_WRITE, 8'h5A);
        send_cmd(ubt_pkg::CMD_START, 8'h00);
        run_ticks(262);
        write_wait(8'd1);
        finish_frame();
        set_wait(8'd0);
        send_cmd(ubt_pkg::CMD_WRITE, 8'hC3);
        send_cmd(ubt_pkg::CMD_START, 8'h00);
        finish_frame();
    endtask

    task automatic test_random_phases();
        for (int m = 0; m < 4; m++)
        begin
            set_wait(8'($urandom_range(1, 3)));
            case (m)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 61;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 61;
                end
                default:
                begin
                    send_idle_pct = 20;
                    recv_stall_pct = 20;
                end
            endcase
            random_traffic(60);
        end
    endtask

    // long receiver hold-off while commands keep coming
    task automatic test_backpressure();
        set_wait(8'd2);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 1'b1;
        random_traffic(60);
    endtask

    initial
    begin
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_directed_frames();
        test_wait_extremes();
        test_random_phases();
        test_backpressure();
        quiesce();
        repeat (10)
            @(posedge clk);
        if (err_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
